[rtl/core/dmtt_pkg.sv]
// Shared types and constants of the delayed message timer table.
// Used by every module under rtl/core; depends on nothing.
package dmtt_pkg;

    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = 5;     // holds 0 .. MAX_RESULTS
    localparam int IN_DATA_W   = 104;   // 97 payload bits padded to whole bytes

    typedef enum logic [1:0] {
        K_POST   = 2'd0,
        K_REMOVE = 2'd1,
        K_CLEAR  = 2'd2,
        K_TICK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_FIRED = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              once;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] start;
    } t_entry;

    // One result transfer
    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] fired_id;
        logic            last;
    } t_res;

    // Flags from the shared compare unit
    typedef struct packed {
        logic eq;    // entry id equals key
        logic gt;    // entry id above key
        logic due;   // wrapping elapsed time reached the delay
    } t_cmp;

endpackage

[rtl/core/dmtt_cmp.sv]
// Shared compare unit: id match/order against the key and due test of one entry.
// Depends on dmtt_pkg.
module dmtt_cmp import dmtt_pkg::*; (
    input  t_entry            i_entry,
    input  logic [ID_W-1:0]   i_key,
    input  logic [TIME_W-1:0] i_now,
    output t_cmp              o_cmp
);

    logic [TIME_W-1:0] elapsed;

    assign elapsed   = i_now - i_entry.start;   // wraps mod 2^32
    assign o_cmp.eq  = (i_entry.id == i_key);
    assign o_cmp.gt  = (i_entry.id > i_key);
    assign o_cmp.due = (elapsed >= i_entry.delay);

endmodule

[rtl/core/dmtt_obuf.sv]
// Output register stage: holds one result until the downstream side takes it.
// Depends on dmtt_pkg.
module dmtt_obuf import dmtt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_rdy,
    output logic o_valid,
    input  logic i_tready,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;

    assign o_rdy   = !r_valid || i_tready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rdy) begin
            r_valid <= i_push;
            if (i_push) begin
                r_res <= i_res;
            end
        end
    end

endmodule

[rtl/core/dmtt_seq.sv]
// Sequencer and entry memory of the timer table: search, shift, insert and tick scan.
// Entries stay sorted by id in slots 0 .. count-1. Depends on dmtt_pkg and dmtt_cmp.
module dmtt_seq import dmtt_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_kind             i_kind,
    input  logic [ID_W-1:0]   i_msg_id,
    input  logic              i_once,
    input  logic [TIME_W-1:0] i_delay,
    input  logic [TIME_W-1:0] i_now,
    output logic              o_push,
    input  logic              i_push_rdy,
    output t_res              o_res
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SIZE);

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_SHUP, S_PUT, S_SHDN, S_TICK, S_FLUSH, S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_wix, n_wix;
    logic              r_grow, n_grow;
    logic [FIRE_W-1:0] r_nfire, n_nfire;
    logic              r_pend_v, n_pend_v;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    t_kind             r_kind, n_kind;
    logic [ID_W-1:0]   r_key, n_key;
    logic              r_once, n_once;
    logic [TIME_W-1:0] r_delay, n_delay;
    logic [TIME_W-1:0] r_now, n_now;
    t_status           r_status, n_status;

    t_entry            r_mem [TABLE_SIZE];
    t_entry            r_rd;
    logic [CW-1:0]     n_rda;
    logic              wr_en;
    logic [CW-1:0]     wr_addr;
    t_entry            wr_data;

    t_cmp              cmp;
    logic              last_idx;
    logic              fire;
    logic              keep;

    dmtt_cmp u_cmp (
        .i_entry (r_rd),
        .i_key   (r_key),
        .i_now   (r_now),
        .o_cmp   (cmp)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign last_idx = (r_idx == (r_cnt - CW'(1)));
    assign fire     = cmp.due && (r_nfire < FIRE_W'(MAX_RESULTS));
    assign keep     = !(fire && r_rd.once);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_wix     = r_wix;
        n_grow    = r_grow;
        n_nfire   = r_nfire;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        n_kind    = r_kind;
        n_key     = r_key;
        n_once    = r_once;
        n_delay   = r_delay;
        n_now     = r_now;
        n_status  = r_status;
        n_rda     = r_idx;
        wr_en     = 1'b0;
        wr_addr   = r_wix;
        wr_data   = r_rd;
        o_push    = 1'b0;
        o_res.status   = r_status;
        o_res.fired_id = '0;
        o_res.last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind   = i_kind;
                    n_key    = i_msg_id;
                    n_once   = i_once;
                    n_delay  = (i_delay == '0) ? TIME_W'(1) : i_delay;
                    n_now    = i_now;
                    n_idx    = '0;
                    n_rda    = '0;
                    n_wix    = '0;
                    n_nfire  = '0;
                    n_pend_v = 1'b0;
                    unique case (i_kind)
                        K_POST: begin
                            if (r_cnt == '0) begin
                                n_grow  = 1'b1;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        K_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ST_DONE;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        K_CLEAR: begin
                            n_cnt    = '0;
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end
                        K_TICK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_NONE;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_TICK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                if (r_kind == K_POST) begin
                    if (cmp.eq) begin
                        n_grow  = 1'b0;
                        n_state = S_PUT;
                    end else if (cmp.gt || last_idx) begin
                        if (r_cnt == FULL_CNT) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if (cmp.gt) begin
                            // open a gap at r_idx: move the tail up from the top
                            n_wix   = r_cnt;
                            n_rda   = r_cnt - CW'(1);
                            n_state = S_SHUP;
                        end else begin
                            n_idx   = r_cnt;
                            n_grow  = 1'b1;
                            n_state = S_PUT;
                        end
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_rda = r_idx + CW'(1);
                    end
                end else begin
                    if (cmp.eq) begin
                        if (last_idx) begin
                            n_cnt    = r_cnt - CW'(1);
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end else begin
                            n_wix   = r_idx;
                            n_rda   = r_idx + CW'(1);
                            n_state = S_SHDN;
                        end
                    end else if (cmp.gt || last_idx) begin
                        n_status = ST_DONE;
                        n_state  = S_RESP;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_rda = r_idx + CW'(1);
                    end
                end
            end
            S_SHUP: begin
                wr_en   = 1'b1;
                wr_addr = r_wix;
                wr_data = r_rd;
                if (r_wix == (r_idx + CW'(1))) begin
                    n_grow  = 1'b1;
                    n_state = S_PUT;
                end else begin
                    n_wix = r_wix - CW'(1);
                    n_rda = r_wix - CW'(2);
                end
            end
            S_PUT: begin
                wr_en         = 1'b1;
                wr_addr       = r_idx;
                wr_data.id    = r_key;
                wr_data.once  = r_once;
                wr_data.delay = r_delay;
                wr_data.start = r_now;
                if (r_grow) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_status = ST_DONE;
                n_state  = S_RESP;
            end
            S_SHDN: begin
                wr_en   = 1'b1;
                wr_addr = r_wix;
                wr_data = r_rd;
                if ((r_wix + CW'(1)) == (r_cnt - CW'(1))) begin
                    n_cnt    = r_cnt - CW'(1);
                    n_status = ST_DONE;
                    n_state  = S_RESP;
                end else begin
                    n_wix = r_wix + CW'(1);
                    n_rda = r_wix + CW'(2);
                end
            end
            S_TICK: begin
                // a new firing releases the one held back before it
                if (fire && r_pend_v) begin
                    o_push         = 1'b1;
                    o_res.status   = ST_FIRED;
                    o_res.fired_id = r_pend_id;
                    o_res.last     = 1'b0;
                end
                if (fire && r_pend_v && !i_push_rdy) begin
                    n_rda = r_idx;
                end else begin
                    if (fire) begin
                        n_nfire   = r_nfire + FIRE_W'(1);
                        n_pend_v  = 1'b1;
                        n_pend_id = r_rd.id;
                    end
                    if (keep) begin
                        wr_en   = 1'b1;
                        wr_addr = r_wix;
                        wr_data = r_rd;
                        if (fire) begin
                            wr_data.start = r_now;
                        end
                        n_wix = r_wix + CW'(1);
                    end
                    if (last_idx) begin
                        n_cnt   = keep ? (r_wix + CW'(1)) : r_wix;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_rda = r_idx + CW'(1);
                    end
                end
            end
            S_FLUSH: begin
                o_push = 1'b1;
                if (r_pend_v) begin
                    o_res.status   = ST_FIRED;
                    o_res.fired_id = r_pend_id;
                end else begin
                    o_res.status   = ST_NONE;
                end
                if (i_push_rdy) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                o_push = 1'b1;
                if (i_push_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_wix    <= '0;
            r_grow   <= 1'b0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_wix     <= n_wix;
            r_grow    <= n_grow;
            r_nfire   <= n_nfire;
            r_pend_v  <= n_pend_v;
            r_pend_id <= n_pend_id;
            r_kind    <= n_kind;
            r_key     <= n_key;
            r_once    <= n_once;
            r_delay   <= n_delay;
            r_now     <= n_now;
            r_status  <= n_status;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[IW-1:0]] <= wr_data;
        end
        r_rd <= r_mem[n_rda[IW-1:0]];
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("entry count above table size");

    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == S_TICK || r_state == S_FLUSH || r_state == S_RESP))
        else $error("result pushed outside a result state");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_wix <= r_idx))
        else $error("compaction pointer overtook scan pointer");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_pend_v == (r_nfire != '0)))
        else $error("held firing disagrees with fire count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_status == ST_FULL) |-> (r_cnt == FULL_CNT))
        else $error("full status with room in the table");

endmodule

[rtl/core/delayed_message_timer_table_unit.sv]
// Top level of the delayed message timer table: stream ports, field unpacking,
// sequencer with entry memory and output register. Depends on dmtt_pkg, dmtt_seq, dmtt_obuf.
//
//  Channel   Direction  Ports                         Carries
//  s         in         i_s_tvalid/o_s_tready/data    post, remove, clear or tick command
//  m         out        o_m_tvalid/i_m_tready/data    status and fired id, tlast on final
//
// Flow: one command at a time; o_s_tready is high only while the sequencer idles.
//   Clear only zeroes the fill count. Remove and post search the live entries in id order;
//   post and remove also move one entry per step when opening or closing a gap.
//   Tick visits each live entry once, one compare per entry through the shared compare unit.
// Reset: synchronous, active low; empties the table (fill count to zero), no clearing pass.
// Stalls: a held-back output freezes the tick scan on the entry being looked at.
module delayed_message_timer_table_unit import dmtt_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,   // msg_id[31:0], once[32], delay[64:33], now[96:65]
    input  logic [1:0]           i_s_tuser,   // kind[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [ID_W-1:0]      o_m_tdata,   // fired_id[31:0]
    output logic [1:0]           o_m_tuser,   // status[1:0]
    output logic                 o_m_tlast
);

    logic push;
    logic push_rdy;
    t_res seq_res;
    t_res out_res;

    // Unpack the command fields and run the table
    dmtt_seq #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_kind     (t_kind'(i_s_tuser)),
        .i_msg_id   (i_s_tdata[31:0]),
        .i_once     (i_s_tdata[32]),
        .i_delay    (i_s_tdata[64:33]),
        .i_now      (i_s_tdata[96:65]),
        .o_push     (push),
        .i_push_rdy (push_rdy),
        .o_res      (seq_res)
    );

    // Hold each result transfer until taken downstream
    dmtt_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res    (seq_res),
        .o_rdy    (push_rdy),
        .o_valid  (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_res    (out_res)
    );

    assign o_m_tdata = out_res.fired_id;
    assign o_m_tuser = out_res.status;
    assign o_m_tlast = out_res.last;

endmodule

[sim/delayed_message_timer_table_unit_tb.sv]
// Self-checking testbench of delayed_message_timer_table_unit: directed and random
// post/remove/clear/tick commands with random stalls on both stream channels.
// Depends on dmtt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module delayed_message_timer_table_unit_tb import dmtt_pkg::*;;

    localparam int SLOTS       = 16;
    localparam int IDLE_PCT    = 21;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS  = 150;
    localparam int POOL_SIZE   = 24;

    // Shadow of the timer table: predicts the result transfers of each command
    // and holds them until the block delivers them.
    class timer_table_checker;
        bit        slot_used  [SLOTS];
        bit [31:0] slot_id    [SLOTS];
        bit        slot_once  [SLOTS];
        bit [31:0] slot_delay [SLOTS];
        bit [31:0] slot_start [SLOTS];
        t_res      owed_results[$];
        int        mismatches;
        int        seen_total;
        int        seen_fired;
        int        seen_full;
        int        seen_none;

        function void push_result(t_status st, bit [31:0] id, bit last);
            t_res r;
            r.status   = st;
            r.fired_id = id;
            r.last     = last;
            owed_results.push_back(r);
        endfunction

        function int find_slot(bit [31:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_id[i] == id) return i;
            return -1;
        endfunction

        // Visit live entries in ascending id order and fire each due one, at most MAX_RESULTS.
        function void run_tick(bit [31:0] stamp);
            int        order [SLOTS];
            int        n;
            int        j;
            int        s;
            int        fired;
            bit [31:0] elapsed;
            n     = 0;
            fired = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    j = n;
                    while (j > 0 && slot_id[order[j-1]] > slot_id[i]) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = i;
                    n++;
                end
            end
            for (int i = 0; i < n && fired < MAX_RESULTS; i++) begin
                s       = order[i];
                elapsed = stamp - slot_start[s];
                if (elapsed >= slot_delay[s]) begin
                    if (slot_once[s]) slot_used[s] = 1'b0;
                    else              slot_start[s] = stamp;
                    push_result(ST_FIRED, slot_id[s], 1'b0);
                    fired++;
                end
            end
            if (fired == 0) push_result(ST_NONE, 32'h0, 1'b1);
            else            owed_results[owed_results.size()-1].last = 1'b1;
        endfunction

        function void note_command(t_kind kind, bit [31:0] id, bit once,
                                   bit [31:0] dly, bit [31:0] stamp);
            int slot;
            case (kind)
                K_POST: begin
                    if (dly == 32'h0) dly = 32'h1;
                    slot = find_slot(id);
                    if (slot < 0) begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!slot_used[i]) slot = i;
                    end
                    if (slot < 0) begin
                        push_result(ST_FULL, 32'h0, 1'b1);
                    end else begin
                        slot_used[slot]  = 1'b1;
                        slot_id[slot]    = id;
                        slot_once[slot]  = once;
                        slot_delay[slot] = dly;
                        slot_start[slot] = stamp;
                        push_result(ST_DONE, 32'h0, 1'b1);
                    end
                end
                K_REMOVE: begin
                    slot = find_slot(id);
                    if (slot >= 0) slot_used[slot] = 1'b0;
                    push_result(ST_DONE, 32'h0, 1'b1);
                end
                K_CLEAR: begin
                    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
                    push_result(ST_DONE, 32'h0, 1'b1);
                end
                default: run_tick(stamp);
            endcase
        endfunction

        function void check_transfer(t_status st, bit [31:0] id, bit last);
            t_res want;
            seen_total++;
            if (st == ST_FIRED) seen_fired++;
            if (st == ST_FULL)  seen_full++;
            if (st == ST_NONE)  seen_none++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: status %0d id %h last %0b",
                             st, id, last);
                return;
            end
            want = owed_results.pop_front();
            if (want.status != st || want.fired_id != id || want.last != last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: status exp %0d got %0d, id exp %h got %h, ",
                              "last exp %0b got %0b"},
                             want.status, st, want.fired_id, id, want.last, last);
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic [IN_DATA_W-1:0] s_data     = '0;
    logic [1:0]           s_user     = 2'b00;
    logic                 m_ready    = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [ID_W-1:0]      m_data;
    logic [1:0]           m_user;
    logic                 m_last;

    timer_table_checker   shadow;
    bit                   calm       = 1'b0;   // suppress idling on both channels
    int                   stall_cycles = 0;
    int                   items_sent = 0;
    bit [31:0]            id_pool [POOL_SIZE];
    bit [31:0]            clock_now;

    delayed_message_timer_table_unit #(.TABLE_SIZE(SLOTS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),    // msg_id[31:0], once[32], delay[64:33], now[96:65]
        .i_s_tuser  (s_user),    // kind[1:0]
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),    // fired_id[31:0]
        .o_m_tuser  (m_user),    // status[1:0]
        .o_m_tlast  (m_last)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: hold back the output channel at random unless in a calm stretch.
    always @(negedge i_clk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check every accepted result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            shadow.check_transfer(t_status'(m_user), m_data, m_last);
    end

    // Count cycles in which neither channel moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Present one command and hold it until accepted. Entered and left just after a
    // falling edge; tvalid is left high so that a following command follows on directly.
    task automatic send_item(t_kind kind, bit [31:0] id, bit once,
                             bit [31:0] dly, bit [31:0] stamp);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[31:0]  = id;
        word[32]    = once;
        word[64:33] = dly;
        word[96:65] = stamp;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_user  <= kind;
        do @(posedge i_clk); while (!s_ready);
        shadow.note_command(kind, id, once, dly, stamp);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until every predicted result has been delivered.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
    endtask

    // Mostly pool ids and small delays so that posts replace, removes hit and the
    // table fills; occasional full-range values and time jumps for the wide fields.
    task automatic random_item();
        int        r;
        t_kind     kind;
        bit [31:0] id;
        bit [31:0] dly;
        r = $urandom_range(0, 99);
        if (r < 42)      kind = K_POST;
        else if (r < 57) kind = K_REMOVE;
        else if (r < 61) kind = K_CLEAR;
        else             kind = K_TICK;
        if ($urandom_range(0, 9) == 0) id = $urandom;
        else                           id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 99);
        if (r < 8)       dly = 32'h0;
        else if (r < 14) dly = $urandom;
        else if (r < 18) dly = 32'hFFFF_FFFF;
        else             dly = $urandom_range(1, 24);
        if ($urandom_range(0, 99) < 5) clock_now = $urandom;
        else                           clock_now = clock_now + $urandom_range(0, 6);
        send_item(kind, id, 1'($urandom_range(0, 1)), dly, clock_now);
    endtask

    initial begin
        shadow = new();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
        clock_now = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero delay counts as one: not due at the same time, due one tick later.
        send_item(K_POST, 32'h0000_0000, 1'b1, 32'h0, 32'd100);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'd100);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'd101);
        // Widest id, delay and time; elapsed time wraps through zero.
        send_item(K_POST, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(K_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'hFFFF_FFFF);
        // Replace in place, then remove an absent and a present id.
        send_item(K_POST, 32'hFFFF_FFFF, 1'b1, 32'd5, 32'd7);
        send_item(K_REMOVE, 32'h1234_5678, 1'b0, 32'h0, 32'h0);
        send_item(K_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'd1000);
        // Fill the table in falling id order, overflow it, replace while full,
        // then fire all sixteen in one tick.
        for (int i = 0; i < SLOTS; i++)
            send_item(K_POST, 32'hF000_0000 - 32'(i) * 32'h0F0F_0F0F, i[0], 32'd3, 32'd50);
        send_item(K_POST, 32'h0000_0042, 1'b0, 32'd1, 32'd50);
        send_item(K_POST, 32'hF000_0000, 1'b0, 32'd2, 32'd51);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'd53);
        send_item(K_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(K_TICK, 32'h0, 1'b0, 32'h0, 32'd60);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 40) drain_results();   // hold the sender until the output is quiet
            calm = (n >= 70 && n < 120);
            random_item();
        end
        calm = 1'b0;
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("sent %0d commands, checked %0d results: %0d fired, %0d full, %0d none due",
                 items_sent, shadow.seen_total, shadow.seen_fired, shadow.seen_full,
                 shadow.seen_none);
        $display("mismatches %0d, results still owed %0d", shadow.mismatches, shadow.pending());
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
